// File: src/dswu_pkg.sv
// Shared types, opcodes and microcode program for the data stack word unit.
package dswu_pkg;

    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_WORD_WIDTH  = 32;
    localparam int IO_WIDTH        = 32;
    localparam int COUNT_WIDTH     = 5;

    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_DROP = 3'd1,
        OP_SWAP = 3'd2,
        OP_OVER = 3'd3,
        OP_ROT  = 3'd4,
        OP_MAX  = 3'd5,
        OP_MIN  = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } status_t;

    // Memory address source
    typedef enum logic [2:0] {
        AS_D    = 3'd0,
        AS_D1   = 3'd1,
        AS_D2   = 3'd2,
        AS_D3   = 3'd3,
        AS_IDX  = 3'd4,
        AS_ZERO = 3'd5
    } addr_sel_t;

    // Memory write data source
    typedef enum logic [1:0] {
        WS_PV   = 2'd0,
        WS_RD   = 2'd1,
        WS_A    = 2'd2,
        WS_BEST = 2'd3
    } wr_sel_t;

    typedef enum logic [1:0] {
        DO_HOLD = 2'd0,
        DO_INC  = 2'd1,
        DO_DEC  = 2'd2,
        DO_ONE  = 2'd3
    } dep_op_t;

    typedef enum logic [1:0] {
        IO_HOLD = 2'd0,
        IO_ONE  = 2'd1,
        IO_INC  = 2'd2
    } idx_op_t;

    typedef enum logic [1:0] {
        J_NONE   = 2'd0,
        J_ALWAYS = 2'd1,
        J_IDX_LT = 2'd2,
        J_IDX_GE = 2'd3
    } jmp_t;

    typedef logic [4:0] upc_t;

    // Microcode addresses
    localparam upc_t UA_PUSH  = 5'd0;
    localparam upc_t UA_DROP  = 5'd1;
    localparam upc_t UA_SWAP0 = 5'd2;
    localparam upc_t UA_SWAP1 = 5'd3;
    localparam upc_t UA_SWAP2 = 5'd4;
    localparam upc_t UA_SWAP3 = 5'd5;
    localparam upc_t UA_OVER0 = 5'd6;
    localparam upc_t UA_OVER1 = 5'd7;
    localparam upc_t UA_ROT0  = 5'd8;
    localparam upc_t UA_ROT1  = 5'd9;
    localparam upc_t UA_ROT2  = 5'd10;
    localparam upc_t UA_ROT3  = 5'd11;
    localparam upc_t UA_ROT4  = 5'd12;
    localparam upc_t UA_ROT5  = 5'd13;
    localparam upc_t UA_SCAN0 = 5'd14;
    localparam upc_t UA_SCAN1 = 5'd15;
    localparam upc_t UA_SCAN2 = 5'd16;
    localparam upc_t UA_SCAN3 = 5'd17;
    localparam upc_t UA_FIN0  = 5'd18;
    localparam upc_t UA_FIN1  = 5'd19;

    typedef struct packed {
        addr_sel_t addr_sel;
        logic      mem_rd;
        logic      mem_wr;
        wr_sel_t   wr_sel;
        logic      ld_a;
        logic      ld_best;
        logic      cmp_upd;
        dep_op_t   dep_op;
        idx_op_t   idx_op;
        jmp_t      jmp;
        upc_t      target;
        logic      done;
    } ctrl_t;

    // Flags returned from the datapath to the sequencer
    typedef struct packed {
        logic idx_lt_d;
    } flags_t;

    localparam ctrl_t CTRL_IDLE = ctrl_t'('0);

    // Control store: one control word per step
    function automatic ctrl_t ucode_rom(upc_t upc);
        ctrl_t c;
        c = CTRL_IDLE;
        case (upc)
            UA_PUSH:
            begin
                c.addr_sel = AS_D;   c.mem_wr = 1'b1; c.wr_sel = WS_PV;
                c.dep_op = DO_INC;   c.jmp = J_ALWAYS; c.target = UA_FIN0;
            end
            UA_DROP:
            begin
                c.dep_op = DO_DEC;   c.jmp = J_ALWAYS; c.target = UA_FIN0;
            end
            UA_SWAP0:
            begin
                c.addr_sel = AS_D1;  c.mem_rd = 1'b1;
            end
            UA_SWAP1:
            begin
                c.addr_sel = AS_D2;  c.mem_rd = 1'b1; c.ld_a = 1'b1;
            end
            UA_SWAP2:
            begin
                c.addr_sel = AS_D1;  c.mem_wr = 1'b1; c.wr_sel = WS_RD;
            end
            UA_SWAP3:
            begin
                c.addr_sel = AS_D2;  c.mem_wr = 1'b1; c.wr_sel = WS_A;
                c.jmp = J_ALWAYS;    c.target = UA_FIN0;
            end
            UA_OVER0:
            begin
                c.addr_sel = AS_D2;  c.mem_rd = 1'b1;
            end
            UA_OVER1:
            begin
                c.addr_sel = AS_D;   c.mem_wr = 1'b1; c.wr_sel = WS_RD;
                c.dep_op = DO_INC;   c.jmp = J_ALWAYS; c.target = UA_FIN0;
            end
            UA_ROT0:
            begin
                c.addr_sel = AS_D3;  c.mem_rd = 1'b1;
            end
            UA_ROT1:
            begin
                c.addr_sel = AS_D2;  c.mem_rd = 1'b1; c.ld_a = 1'b1;
            end
            UA_ROT2:
            begin
                c.addr_sel = AS_D3;  c.mem_wr = 1'b1; c.wr_sel = WS_RD;
            end
            UA_ROT3:
            begin
                c.addr_sel = AS_D1;  c.mem_rd = 1'b1;
            end
            UA_ROT4:
            begin
                c.addr_sel = AS_D2;  c.mem_wr = 1'b1; c.wr_sel = WS_RD;
            end
            UA_ROT5:
            begin
                c.addr_sel = AS_D1;  c.mem_wr = 1'b1; c.wr_sel = WS_A;
                c.jmp = J_ALWAYS;    c.target = UA_FIN0;
            end
            UA_SCAN0:
            begin
                c.addr_sel = AS_ZERO; c.mem_rd = 1'b1; c.idx_op = IO_ONE;
            end
            UA_SCAN1:
            begin
                c.addr_sel = AS_IDX; c.mem_rd = 1'b1; c.ld_best = 1'b1;
                c.idx_op = IO_INC;   c.jmp = J_IDX_GE; c.target = UA_SCAN3;
            end
            UA_SCAN2:
            begin
                c.addr_sel = AS_IDX; c.mem_rd = 1'b1; c.cmp_upd = 1'b1;
                c.idx_op = IO_INC;   c.jmp = J_IDX_LT; c.target = UA_SCAN2;
            end
            UA_SCAN3:
            begin
                c.addr_sel = AS_ZERO; c.mem_wr = 1'b1; c.wr_sel = WS_BEST;
                c.dep_op = DO_ONE;   c.jmp = J_ALWAYS; c.target = UA_FIN0;
            end
            UA_FIN0:
            begin
                c.addr_sel = AS_D1;  c.mem_rd = 1'b1;
            end
            UA_FIN1:
            begin
                c.done = 1'b1;
            end
            default:
            begin
                c = CTRL_IDLE;
            end
        endcase
        return c;
    endfunction

    // Dispatch table: first step of each operation
    function automatic upc_t entry_point(op_t op);
        upc_t ua;
        case (op)
            OP_PUSH: ua = UA_PUSH;
            OP_DROP: ua = UA_DROP;
            OP_SWAP: ua = UA_SWAP0;
            OP_OVER: ua = UA_OVER0;
            OP_ROT:  ua = UA_ROT0;
            OP_MAX:  ua = UA_SCAN0;
            OP_MIN:  ua = UA_SCAN0;
            default: ua = UA_FIN0;
        endcase
        return ua;
    endfunction

endpackage

// File: src/dswu_seq.sv
// Microcode sequencer: step counter, control store lookup and jumps.
module dswu_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  dswu_pkg::upc_t   entry,
    input  dswu_pkg::flags_t flags,
    input  logic             hold,
    output dswu_pkg::ctrl_t  ctrl,
    output logic             busy
);
    import dswu_pkg::*;

    upc_t  upc_reg;
    upc_t  upc_next;
    logic  busy_reg;
    logic  busy_next;
    ctrl_t rom_word;
    logic  taken;

    // Look up the current control word and resolve the jump condition
    always_comb
    begin
        rom_word = ucode_rom(upc_reg);
        case (rom_word.jmp)
            J_NONE:   taken = 1'b0;
            J_ALWAYS: taken = 1'b1;
            J_IDX_LT: taken = flags.idx_lt_d;
            J_IDX_GE: taken = !flags.idx_lt_d;
            default:  taken = 1'b0;
        endcase
    end

    // Advance the step counter; hold on the last step while the output is full
    always_comb
    begin
        upc_next  = upc_reg;
        busy_next = busy_reg;
        if (start)
        begin
            upc_next  = entry;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rom_word.done)
            begin
                if (!hold)
                begin
                    busy_next = 1'b0;
                end
            end
            else if (taken)
            begin
                upc_next = rom_word.target;
            end
            else
            begin
                upc_next = upc_reg + upc_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg  <= UA_FIN1;
            busy_reg <= 1'b0;
        end
        else
        begin
            upc_reg  <= upc_next;
            busy_reg <= busy_next;
        end
    end

    assign ctrl = busy_reg ? rom_word : CTRL_IDLE;
    assign busy = busy_reg;

endmodule

// File: src/dswu_dpath.sv
// Stack datapath: entry memory, depth counter, temporaries and scan compare.
module dswu_dpath #(
    parameter int STACK_DEPTH = dswu_pkg::DEF_STACK_DEPTH,
    parameter int WORD_WIDTH  = dswu_pkg::DEF_WORD_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [2:0]                           mode,
    input  logic signed [dswu_pkg::IO_WIDTH-1:0] push_value,
    input  dswu_pkg::ctrl_t                      ctrl,
    output dswu_pkg::flags_t                     flags,
    output logic                                 refuse,
    output logic signed [dswu_pkg::IO_WIDTH-1:0] top_word,
    output logic                                 top_nonempty,
    output logic [dswu_pkg::COUNT_WIDTH-1:0]     count,
    output logic [1:0]                           status_code
);
    import dswu_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [WORD_WIDTH-1:0] store_mem [STACK_DEPTH];
    logic [WORD_WIDTH-1:0] rd_data_reg;
    logic [WORD_WIDTH-1:0] pv_reg;
    logic [WORD_WIDTH-1:0] a_reg;
    logic [WORD_WIDTH-1:0] best_reg;
    logic [DW-1:0]         depth_reg;
    logic [DW-1:0]         depth_next;
    logic [DW-1:0]         idx_reg;
    logic [DW-1:0]         idx_next;
    logic                  is_max_reg;
    status_t               status_reg;
    status_t               status_calc;
    logic [DW-1:0]         addr_full;
    logic [AW-1:0]         mem_addr;
    logic [WORD_WIDTH-1:0] wr_data;
    logic                  full;
    logic                  take;
    logic [WORD_WIDTH+IO_WIDTH-1:0]    pv_ext;
    logic [WORD_WIDTH+IO_WIDTH-1:0]    top_ext;
    logic [DW+COUNT_WIDTH-1:0]         cnt_ext;

    // Check entry requirements of the incoming transaction
    always_comb
    begin
        full = (depth_reg >= DW'(STACK_DEPTH));
        case (op_t'(mode))
            OP_PUSH: status_calc = full ? ST_OVER : ST_DONE;
            OP_DROP,
            OP_MAX,
            OP_MIN:  status_calc = (depth_reg < DW'(1)) ? ST_UNDER : ST_DONE;
            OP_SWAP: status_calc = (depth_reg < DW'(2)) ? ST_UNDER : ST_DONE;
            OP_OVER: status_calc = (depth_reg < DW'(2)) ? ST_UNDER :
                                   (full ? ST_OVER : ST_DONE);
            OP_ROT:  status_calc = (depth_reg < DW'(3)) ? ST_UNDER : ST_DONE;
            default: status_calc = ST_DONE;
        endcase
    end
    assign refuse = (status_calc != ST_DONE);

    // Select the memory address
    always_comb
    begin
        case (ctrl.addr_sel)
            AS_D:    addr_full = depth_reg;
            AS_D1:   addr_full = depth_reg - DW'(1);
            AS_D2:   addr_full = depth_reg - DW'(2);
            AS_D3:   addr_full = depth_reg - DW'(3);
            AS_IDX:  addr_full = idx_reg;
            AS_ZERO: addr_full = '0;
            default: addr_full = '0;
        endcase
    end
    assign mem_addr = addr_full[AW-1:0];

    // Select the memory write data
    always_comb
    begin
        case (ctrl.wr_sel)
            WS_PV:   wr_data = pv_reg;
            WS_RD:   wr_data = rd_data_reg;
            WS_A:    wr_data = a_reg;
            WS_BEST: wr_data = best_reg;
            default: wr_data = pv_reg;
        endcase
    end

    // Signed compare for the max/min scan
    assign take = is_max_reg ? ($signed(rd_data_reg) > $signed(best_reg))
                             : ($signed(rd_data_reg) < $signed(best_reg));

    // Update depth and scan index
    always_comb
    begin
        case (ctrl.dep_op)
            DO_HOLD: depth_next = depth_reg;
            DO_INC:  depth_next = depth_reg + DW'(1);
            DO_DEC:  depth_next = depth_reg - DW'(1);
            DO_ONE:  depth_next = DW'(1);
            default: depth_next = depth_reg;
        endcase
        case (ctrl.idx_op)
            IO_HOLD: idx_next = idx_reg;
            IO_ONE:  idx_next = DW'(1);
            IO_INC:  idx_next = idx_reg + DW'(1);
            default: idx_next = idx_reg;
        endcase
    end

    assign pv_ext = {{WORD_WIDTH{push_value[IO_WIDTH-1]}}, push_value};

    // Single-port entry memory with registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.mem_wr)
        begin
            store_mem[mem_addr] <= wr_data;
        end
        if (ctrl.mem_rd)
        begin
            rd_data_reg <= store_mem[mem_addr];
        end
    end

    // Capture operands and temporaries
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            pv_reg <= pv_ext[WORD_WIDTH-1:0];
        end
        if (ctrl.ld_a)
        begin
            a_reg <= rd_data_reg;
        end
        if (ctrl.ld_best || (ctrl.cmp_upd && take))
        begin
            best_reg <= rd_data_reg;
        end
        idx_reg <= idx_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= '0;
            status_reg <= ST_DONE;
            is_max_reg <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            if (start)
            begin
                status_reg <= status_calc;
                is_max_reg <= (op_t'(mode) == OP_MAX);
            end
        end
    end

    // Format the result fields
    assign flags.idx_lt_d = (idx_reg < depth_reg);
    assign top_nonempty   = (depth_reg != '0);
    assign top_ext        = {{IO_WIDTH{rd_data_reg[WORD_WIDTH-1]}}, rd_data_reg};
    assign top_word       = top_nonempty ? top_ext[IO_WIDTH-1:0] : '0;
    assign cnt_ext        = (DW + COUNT_WIDTH)'(depth_reg);
    assign count          = cnt_ext[COUNT_WIDTH-1:0];
    assign status_code    = status_reg;

endmodule

// File: src/data_stack_word_unit.sv
// Throughput: one transaction at a time; the scan loop reads one entry per cycle from
// the single-port stack memory, so max/min takes longest when the stack is full.
// A finished result waits in the output register while the next transaction starts.
// Reset (rst_n low, asynchronous) empties the stack and clears the sequencer;
// stack memory contents are not cleared.
module data_stack_word_unit #(
    parameter int STACK_DEPTH = dswu_pkg::DEF_STACK_DEPTH,
    parameter int WORD_WIDTH  = dswu_pkg::DEF_WORD_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [2:0]                           mode,
    input  logic signed [dswu_pkg::IO_WIDTH-1:0] push_value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [dswu_pkg::IO_WIDTH-1:0] top_value,
    output logic                                 top_valid,
    output logic [dswu_pkg::COUNT_WIDTH-1:0]     entry_count,
    output logic [1:0]                           status
);
    import dswu_pkg::*;

    ctrl_t  ctrl;
    flags_t flags;
    logic   busy;
    logic   start;
    logic   refuse;
    logic   hold;
    logic   load;
    upc_t   entry;

    logic signed [IO_WIDTH-1:0] top_word;
    logic                       top_nonempty;
    logic [COUNT_WIDTH-1:0]     count;
    logic [1:0]                 status_code;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [IO_WIDTH-1:0] top_value_reg;
    logic                       top_valid_reg;
    logic [COUNT_WIDTH-1:0]     entry_count_reg;
    logic [1:0]                 status_reg;

    // Accept a transaction when the sequencer is idle
    assign in_stall = busy;
    assign start    = in_valid && !busy;
    assign entry    = refuse ? UA_FIN0 : entry_point(op_t'(mode));

    // Hold the final step while the output register cannot take a result
    assign hold = out_valid_reg && out_stall;
    assign load = ctrl.done && !hold;

    dswu_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .entry (entry),
        .flags (flags),
        .hold  (hold),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    dswu_dpath #(
        .STACK_DEPTH (STACK_DEPTH),
        .WORD_WIDTH  (WORD_WIDTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .mode         (mode),
        .push_value   (push_value),
        .ctrl         (ctrl),
        .flags        (flags),
        .refuse       (refuse),
        .top_word     (top_word),
        .top_nonempty (top_nonempty),
        .count        (count),
        .status_code  (status_code)
    );

    // Output register valid
    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            top_value_reg   <= top_word;
            top_valid_reg   <= top_nonempty;
            entry_count_reg <= count;
            status_reg      <= status_code;
        end
    end

    assign out_valid   = out_valid_reg;
    assign top_value   = top_value_reg;
    assign top_valid   = top_valid_reg;
    assign entry_count = entry_count_reg;
    assign status      = status_reg;

endmodule
